[src/lfu_pkg.sv]
package lfu_pkg;

	localparam int KEY_W   = 32;
	localparam int DATA_W  = 32;
	localparam int COUNT_W = 16;
	localparam int STAMP_W = 32;
	localparam int CAP_W   = 5;

	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
	localparam logic [CAP_W-1:0]   CAP_RESET = CAP_W'(16);

	localparam logic KIND_GET = 1'b0;
	localparam logic KIND_PUT = 1'b1;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [DATA_W-1:0]  data;
		logic [COUNT_W-1:0] count;
		logic [STAMP_W-1:0] stamp;
	} lfu_row_t;

	typedef struct packed {
		logic load;
		logic scan_rd;
		logic update;
	} lfu_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_UPDATE
	} lfu_state_t;

endpackage

[src/lfu_ctrl.sv]
module lfu_ctrl import lfu_pkg::*; #(
	parameter int ENTRIES = 16,
	parameter int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output logic          done,
	output lfu_cmd_t      cmd,
	output logic [IW-1:0] addr
);

	lfu_state_t state_q, state_d;
	logic [IW-1:0] addr_q, addr_d;
	logic done_q;
	logic last;

	assign last = (addr_q == IW'(ENTRIES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			addr_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			addr_q  <= addr_d;
			done_q  <= (state_q == ST_UPDATE);
		end
	end

	always_comb begin
		state_d     = state_q;
		addr_d      = addr_q;
		cmd.load    = 1'b0;
		cmd.scan_rd = 1'b0;
		cmd.update  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				addr_d = '0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				addr_d      = addr_q + IW'(1);
				if (last) begin
					addr_d  = '0;
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign addr = addr_q;

endmodule

[src/lfu_datapath.sv]
module lfu_datapath import lfu_pkg::*; #(
	parameter int ENTRIES = 16,
	parameter int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lfu_cmd_t           cmd,
	input  logic [IW-1:0]      addr,
	input  logic [CAP_W-1:0]   capacity,
	input  logic               kind,
	input  logic [KEY_W-1:0]   key,
	input  logic [DATA_W-1:0]  value,
	output logic               hit,
	output logic [DATA_W-1:0]  read_value,
	output logic               evicted,
	output logic [KEY_W-1:0]   evicted_key
);

	localparam int OW = $clog2(ENTRIES + 1);
	localparam int CW = (OW > CAP_W) ? OW : CAP_W;

	lfu_row_t mem [ENTRIES];

	logic [ENTRIES-1:0] valid_q;
	logic [OW-1:0]      occ_q;
	logic [STAMP_W-1:0] tick_q;

	logic               kind_q;
	logic [KEY_W-1:0]   key_q;
	logic [DATA_W-1:0]  value_q;

	lfu_row_t      row_s1;
	logic [IW-1:0] idx_s1;
	logic          vld_s1;
	logic          eval_s1;

	logic               match_q;
	logic [IW-1:0]      match_idx_q;
	logic [DATA_W-1:0]  match_data_q;
	logic [COUNT_W-1:0] match_count_q;

	logic          free_q;
	logic [IW-1:0] free_idx_q;

	logic               best_q;
	logic [IW-1:0]      best_idx_q;
	logic [COUNT_W-1:0] best_cnt_q;
	logic [STAMP_W-1:0] best_age_q;
	logic [KEY_W-1:0]   best_key_q;

	logic               hit_q;
	logic [DATA_W-1:0]  rd_q;
	logic               ev_q;
	logic [KEY_W-1:0]   evk_q;

	logic [STAMP_W-1:0] age;
	logic               better;
	logic [CW-1:0]      cap_ext, cap_eff, occ_ext;
	logic [COUNT_W-1:0] count_inc;

	logic               we;
	logic [IW-1:0]      waddr;
	lfu_row_t           wrow;
	logic               set_valid;
	logic               occ_inc;
	logic               ev_d;
	logic [DATA_W-1:0]  rd_d;
	logic [KEY_W-1:0]   evk_d;

	assign age    = tick_q - row_s1.stamp;
	assign better = !best_q || (row_s1.count < best_cnt_q) ||
		((row_s1.count == best_cnt_q) && (age > best_age_q));

	assign cap_ext   = CW'(capacity);
	assign cap_eff   = (cap_ext > CW'(ENTRIES)) ? CW'(ENTRIES) : cap_ext;
	assign occ_ext   = CW'(occ_q);
	assign count_inc = (match_count_q == COUNT_MAX) ? COUNT_MAX : match_count_q + COUNT_W'(1);

	always_comb begin
		we         = 1'b0;
		waddr      = match_idx_q;
		wrow.key   = key_q;
		wrow.data  = value_q;
		wrow.count = count_inc;
		wrow.stamp = tick_q;
		set_valid  = 1'b0;
		occ_inc    = 1'b0;
		ev_d       = 1'b0;
		rd_d       = '0;
		evk_d      = '0;
		if (kind_q == KIND_GET) begin
			if (match_q) begin
				we        = 1'b1;
				wrow.data = match_data_q;
				rd_d      = match_data_q;
			end
		end else if (cap_eff != '0) begin
			if (match_q) begin
				we = 1'b1;
			end else if (occ_ext >= cap_eff) begin
				we         = best_q;
				waddr      = best_idx_q;
				wrow.count = COUNT_W'(1);
				ev_d       = best_q;
				evk_d      = best_q ? best_key_q : '0;
			end else begin
				we         = free_q;
				waddr      = free_idx_q;
				wrow.count = COUNT_W'(1);
				set_valid  = free_q;
				occ_inc    = free_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update && we) begin
			mem[waddr] <= wrow;
		end
		if (cmd.scan_rd) begin
			row_s1 <= mem[addr];
		end
		idx_s1 <= addr;
		vld_s1 <= valid_q[addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q  <= kind;
			key_q   <= key;
			value_q <= value;
		end
		if (eval_s1) begin
			if (vld_s1 && (row_s1.key == key_q) && !match_q) begin
				match_idx_q   <= idx_s1;
				match_data_q  <= row_s1.data;
				match_count_q <= row_s1.count;
			end
			if (!vld_s1 && !free_q) begin
				free_idx_q <= idx_s1;
			end
			if (vld_s1 && better) begin
				best_idx_q <= idx_s1;
				best_cnt_q <= row_s1.count;
				best_age_q <= age;
				best_key_q <= row_s1.key;
			end
		end
		if (cmd.update) begin
			rd_q  <= rd_d;
			evk_q <= evk_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
			tick_q  <= '0;
			eval_s1 <= 1'b0;
			match_q <= 1'b0;
			free_q  <= 1'b0;
			best_q  <= 1'b0;
			hit_q   <= 1'b0;
			ev_q    <= 1'b0;
		end else begin
			eval_s1 <= cmd.scan_rd;
			if (cmd.load) begin
				match_q <= 1'b0;
				free_q  <= 1'b0;
				best_q  <= 1'b0;
			end else if (eval_s1) begin
				if (vld_s1 && (row_s1.key == key_q)) begin
					match_q <= 1'b1;
				end
				if (!vld_s1) begin
					free_q <= 1'b1;
				end
				if (vld_s1) begin
					best_q <= 1'b1;
				end
			end
			if (cmd.update) begin
				if (set_valid) begin
					valid_q[waddr] <= 1'b1;
				end
				if (occ_inc) begin
					occ_q <= occ_q + OW'(1);
				end
				tick_q <= tick_q + STAMP_W'(1);
				hit_q  <= match_q;
				ev_q   <= ev_d;
			end
		end
	end

	assign hit         = hit_q;
	assign read_value  = rd_q;
	assign evicted     = ev_q;
	assign evicted_key = evk_q;

endmodule

[src/lfu_cache_table_top.sv]
// Key/value store of ENTRIES slots with least-frequently-used replacement, ties going
// to the least recently used slot. A word is taken when start is high and busy is low.
// Busy then stays high through the scan, drain and update states. The slot memory
// is scanned one slot per cycle to find the key, the first free slot and the victim.
// A drain state then takes in the last slot that was read, and an update state writes
// the table. Done rises in the same cycle that busy falls. The result is put on hit,
// read_value, evicted and evicted_key in the cycle in which done is high, and is held
// until the next word updates the table. The receiver cannot stall it, so it must
// capture the word in that cycle. A new word may be started in that same cycle, and it
// is taken at the edge that ends it, so a new word is never taken before the last one's
// result is out. The capacity register at address 0 may be written only while busy
// is low and no done strobe is pending.
module lfu_cache_table_top import lfu_pkg::*; #(
	parameter int ENTRIES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               start,
	output logic               busy,
	input  logic               kind,
	input  logic [KEY_W-1:0]   key,
	input  logic [DATA_W-1:0]  value,
	output logic               done,
	output logic               hit,
	output logic [DATA_W-1:0]  read_value,
	output logic               evicted,
	output logic [KEY_W-1:0]   evicted_key
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	logic [CAP_W-1:0] capacity_q;
	lfu_cmd_t         cmd;
	logic [IW-1:0]    addr;
	logic             accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
			capacity_q <= pwdata[CAP_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {{(32 - CAP_W){1'b0}}, capacity_q} : '0;
	assign accept = start && !busy;

	lfu_ctrl #(
		.ENTRIES(ENTRIES),
		.IW     (IW)
	) u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (accept),
		.busy  (busy),
		.done  (done),
		.cmd   (cmd),
		.addr  (addr)
	);

	lfu_datapath #(
		.ENTRIES(ENTRIES),
		.IW     (IW)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.addr       (addr),
		.capacity   (capacity_q),
		.kind       (kind),
		.key        (key),
		.value      (value),
		.hit        (hit),
		.read_value (read_value),
		.evicted    (evicted),
		.evicted_key(evicted_key)
	);

endmodule

[dv/tb_top.sv]
module tb_top import lfu_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ENTRIES = 16;
	localparam int POOL_SIZE = 48;
	localparam longint CYCLE_LIMIT = 400_000;
	localparam logic [2:0] CAPACITY_ADDR = 3'd0;

	typedef struct packed {
		logic              kind;
		logic [KEY_W-1:0]  key;
		logic [DATA_W-1:0] value;
	} cache_op_t;

	typedef struct packed {
		logic              hit;
		logic [DATA_W-1:0] read_value;
		logic              evicted;
		logic [KEY_W-1:0]  evicted_key;
	} cache_outcome_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [2:0]        paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;
	logic              start = 1'b0;
	logic              busy;
	logic              kind = 1'b0;
	logic [KEY_W-1:0]  key = '0;
	logic [DATA_W-1:0] value = '0;
	logic              done;
	logic              hit;
	logic [DATA_W-1:0] read_value;
	logic              evicted;
	logic [KEY_W-1:0]  evicted_key;

	cache_op_t      pending_ops[$];
	cache_outcome_t outcome_q[$];
	logic           word_taken = 1'b0;
	int unsigned    gap_left = 0;
	int unsigned    burst_left = 0;
	bit             no_gaps = 1'b0;
	int unsigned    fail_count = 0;
	int unsigned    results_checked = 0;
	int unsigned    hits_seen = 0;
	int unsigned    evictions_seen = 0;
	longint         cycle_count = 0;

	logic              entry_valid[ENTRIES];
	logic [KEY_W-1:0]  entry_key[ENTRIES];
	logic [DATA_W-1:0] entry_data[ENTRIES];
	logic [COUNT_W-1:0] entry_uses[ENTRIES];
	logic [STAMP_W-1:0] entry_stamp[ENTRIES];
	logic [STAMP_W-1:0] op_tick;
	int unsigned       fill_count;
	int unsigned       cap_setting;
	logic [KEY_W-1:0]  key_pool[POOL_SIZE];
	int unsigned       sweep_caps[10];

	lfu_cache_table_top #(.ENTRIES(ENTRIES)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.start(start),
		.busy(busy),
		.kind(kind),
		.key(key),
		.value(value),
		.done(done),
		.hit(hit),
		.read_value(read_value),
		.evicted(evicted),
		.evicted_key(evicted_key)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void bump_entry(int idx);
		if (entry_uses[idx] != COUNT_MAX)
			entry_uses[idx] = entry_uses[idx] + 1'b1;
		entry_stamp[idx] = op_tick;
	endfunction

	// Applies one word to the table copy and returns the result it should produce.
	function automatic cache_outcome_t access_table(cache_op_t op);
		cache_outcome_t r;
		int found;
		int slot;
		int unsigned lim;
		logic [STAMP_W-1:0] age;
		logic [STAMP_W-1:0] best_age;
		logic [COUNT_W-1:0] best_uses;
		r = '0;
		found = -1;
		slot = -1;
		best_age = '0;
		best_uses = '0;
		lim = (cap_setting > ENTRIES) ? ENTRIES : cap_setting;
		for (int i = 0; i < ENTRIES; i++)
			if (found < 0 && entry_valid[i] && entry_key[i] == op.key)
				found = i;
		r.hit = (found >= 0);
		if (op.kind == KIND_GET) begin
			if (found >= 0) begin
				r.read_value = entry_data[found];
				bump_entry(found);
			end
		end else if (lim != 0) begin
			if (found >= 0) begin
				entry_data[found] = op.value;
				bump_entry(found);
			end else begin
				if (fill_count >= lim) begin
					for (int i = 0; i < ENTRIES; i++) begin
						if (entry_valid[i]) begin
							age = op_tick - entry_stamp[i];
							if (slot < 0 || entry_uses[i] < best_uses ||
								(entry_uses[i] == best_uses && age > best_age)) begin
								slot = i;
								best_uses = entry_uses[i];
								best_age = age;
							end
						end
					end
					if (slot >= 0) begin
						r.evicted = 1'b1;
						r.evicted_key = entry_key[slot];
					end
				end else begin
					for (int i = 0; i < ENTRIES; i++)
						if (slot < 0 && !entry_valid[i])
							slot = i;
					if (slot >= 0)
						fill_count++;
				end
				if (slot >= 0) begin
					entry_valid[slot] = 1'b1;
					entry_key[slot] = op.key;
					entry_data[slot] = op.value;
					entry_uses[slot] = COUNT_W'(1);
					entry_stamp[slot] = op_tick;
				end
			end
		end
		op_tick = op_tick + 1'b1;
		return r;
	endfunction

	function automatic cache_op_t random_op(int unsigned span);
		cache_op_t op;
		op.kind = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 99) < 80)
			op.key = key_pool[$urandom_range(0, $urandom_range(0, span))];
		else
			op.key = $urandom;
		case ($urandom_range(0, 9))
			0: op.value = 32'h8000_0000;
			1: op.value = 32'h7fff_ffff;
			default: op.value = $urandom;
		endcase
		return op;
	endfunction

	task automatic queue_op(logic k, logic [KEY_W-1:0] kk, logic [DATA_W-1:0] v);
		pending_ops.push_back(cache_op_t'{k, kk, v});
	endtask

	task automatic drain_and_settle();
		while (pending_ops.size() != 0 || start || outcome_q.size() != 0)
			@(posedge clk);
		repeat (ENTRIES + 8) @(posedge clk);
	endtask

	task automatic write_capacity(int unsigned cap);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = CAPACITY_ADDR;
		pwdata = cap;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		@(negedge clk);
		if (prdata !== (cap & 32'h1f)) begin
			$error("prdata: expected %h, got %h", cap & 32'h1f, prdata);
			fail_count++;
		end
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		cap_setting = cap & 32'h1f;
	endtask

	always @(negedge clk) begin
		cache_op_t nxt;
		if (!start || word_taken) begin
			if (gap_left > 0 || pending_ops.size() == 0) begin
				if (gap_left > 0)
					gap_left <= gap_left - 1;
				start <= 1'b0;
				kind <= 1'($urandom_range(0, 1));
				key <= $urandom;
				value <= $urandom;
			end else begin
				nxt = pending_ops.pop_front();
				start <= 1'b1;
				kind <= nxt.kind;
				key <= nxt.key;
				value <= nxt.value;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left <= no_gaps ? 0 : $urandom_range(0, 25);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	always @(posedge clk) begin
		cache_outcome_t want;
		cache_outcome_t got;
		got = {hit, read_value, evicted, evicted_key};
		if (arst_n && done === 1'b1) begin
			if (outcome_q.size() == 0) begin
				$error("Result word arrived with no word outstanding.");
				fail_count++;
			end else begin
				want = outcome_q.pop_front();
				results_checked++;
				if (want.hit)
					hits_seen++;
				if (want.evicted)
					evictions_seen++;
				if (got.hit !== want.hit) begin
					$error("hit: expected %0d, got %0d", want.hit, got.hit);
					fail_count++;
				end
				if (got.read_value !== want.read_value) begin
					$error("read_value: expected %h, got %h", want.read_value, got.read_value);
					fail_count++;
				end
				if (got.evicted !== want.evicted) begin
					$error("evicted: expected %0d, got %0d", want.evicted, got.evicted);
					fail_count++;
				end
				if (got.evicted_key !== want.evicted_key) begin
					$error("evicted_key: expected %h, got %h",
						want.evicted_key, got.evicted_key);
					fail_count++;
				end
			end
		end
		word_taken <= arst_n && start && busy === 1'b0;
		if (arst_n && start && busy === 1'b0)
			outcome_q.push_back(access_table(cache_op_t'{kind, key, value}));
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d words outstanding.",
				cycle_count, outcome_q.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int unsigned lim;
		int unsigned span;
		int unsigned n;
		for (int i = 0; i < ENTRIES; i++) begin
			entry_valid[i] = 1'b0;
			entry_key[i] = '0;
			entry_data[i] = '0;
			entry_uses[i] = '0;
			entry_stamp[i] = '0;
		end
		op_tick = '0;
		fill_count = 0;
		cap_setting = CAP_RESET;
		for (int i = 0; i < POOL_SIZE; i++)
			key_pool[i] = $urandom;
		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7fff_ffff;
		key_pool[2] = 32'h0000_0000;
		key_pool[3] = 32'hffff_ffff;
		sweep_caps = '{16, 5, 1, 0, 31, 17, 3, 8, 2, 16};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		queue_op(KIND_GET, 32'h0000_0000, 32'hdead_beef);
		queue_op(KIND_PUT, 32'h8000_0000, 32'h7fff_ffff);
		queue_op(KIND_PUT, 32'h7fff_ffff, 32'h8000_0000);
		queue_op(KIND_PUT, 32'h0000_0000, 32'h0000_0000);
		queue_op(KIND_PUT, 32'hffff_ffff, 32'hffff_ffff);
		queue_op(KIND_GET, 32'h8000_0000, 32'h0000_0000);
		queue_op(KIND_GET, 32'h7fff_ffff, 32'hffff_ffff);
		queue_op(KIND_PUT, 32'h0000_0000, 32'h1234_5678);
		queue_op(KIND_GET, 32'h0000_0000, 32'h0000_0000);
		queue_op(KIND_GET, 32'hffff_ffff, 32'h0000_0000);
		queue_op(KIND_PUT, 32'h0000_0001, 32'h0000_0005);
		drain_and_settle();

		// Shrinking below the number of stored entries forces replacement.
		write_capacity(2);
		queue_op(KIND_PUT, 32'h0000_0002, 32'h0000_0006);
		queue_op(KIND_PUT, 32'h0000_0003, 32'h0000_0007);
		queue_op(KIND_PUT, 32'h0000_0004, 32'h0000_0008);
		queue_op(KIND_GET, 32'h0000_0004, 32'h0000_0000);
		queue_op(KIND_PUT, 32'h0000_0005, 32'h0000_0009);
		drain_and_settle();

		write_capacity(0);
		queue_op(KIND_PUT, 32'h5555_5555, 32'h0000_0001);
		queue_op(KIND_PUT, 32'h0000_0000, 32'h0000_0063);
		queue_op(KIND_GET, 32'h0000_0000, 32'h0000_0000);
		queue_op(KIND_GET, 32'h5555_5555, 32'h0000_0000);
		drain_and_settle();

		write_capacity(31);
		queue_op(KIND_PUT, 32'h5555_5555, 32'haaaa_aaaa);
		queue_op(KIND_GET, 32'h5555_5555, 32'h0000_0000);
		queue_op(KIND_PUT, 32'haaaa_aaaa, 32'h5555_5555);
		queue_op(KIND_GET, 32'haaaa_aaaa, 32'h0000_0000);
		drain_and_settle();

		for (int p = 0; p < 10; p++) begin
			write_capacity(sweep_caps[p]);
			no_gaps = (p % 3 == 1);
			lim = (sweep_caps[p] > ENTRIES) ? ENTRIES : sweep_caps[p];
			span = (lim + 6 < POOL_SIZE) ? lim + 6 : POOL_SIZE - 1;
			n = $urandom_range(150, 230);
			for (int i = 0; i < n; i++)
				pending_ops.push_back(random_op(span));
			drain_and_settle();
		end

		$display("Checked %0d result words, %0d hits and %0d evictions among them.",
			results_checked, hits_seen, evictions_seen);
		$display("Capacities 0, 1, 2, 3, 5, 8, 16, 17 and 31 were used, %s",
			"with bursts, gaps and back-to-back starts.");
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
